FILE: rtl/core/tcd_pkg.sv
// Shared types, codes and constants for the teletype console device core.
package tcd_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_OFFSET = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPCASE        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TELNET        = 4'd3;

    // Item kinds
    localparam logic [1:0] CMD_IO_INSN = 2'd0;
    localparam logic [1:0] CMD_KB_BYTE = 2'd1;
    localparam logic [1:0] CMD_PR_DONE = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // First opcode of the device at offset zero
    localparam logic [11:0] IO_BASE = 12'o6030;

    // Operation codes relative to the device base
    localparam logic [11:0] REL_KCF = 12'o00;
    localparam logic [11:0] REL_KSF = 12'o01;
    localparam logic [11:0] REL_KCC = 12'o02;
    localparam logic [11:0] REL_KRS = 12'o04;
    localparam logic [11:0] REL_KIE = 12'o05;
    localparam logic [11:0] REL_KRB = 12'o06;
    localparam logic [11:0] REL_TFL = 12'o10;
    localparam logic [11:0] REL_TSF = 12'o11;
    localparam logic [11:0] REL_TCF = 12'o12;
    localparam logic [11:0] REL_TPC = 12'o14;
    localparam logic [11:0] REL_TSK = 12'o15;
    localparam logic [11:0] REL_TLS = 12'o16;

    localparam logic [7:0] TELNET_IAC = 8'd255;
    localparam logic [6:0] CHAR_LC_A  = 7'h61;
    localparam logic [6:0] CHAR_LC_Z  = 7'h7a;
    localparam logic [7:0] CASE_DIFF  = 8'o040;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] opcode;
        logic [12:0] ac_in;
        logic [7:0]  kb_byte;
        logic        irq_inhibit;
        logic        other_tty_irq;
    } t_tcd_in;

    typedef struct packed {
        logic [12:0] ac_out;
        logic        skip;
        logic        unsupported;
        logic        int_request;
        logic        print_valid;
        logic [7:0]  print_char;
    } t_tcd_out;

    typedef struct packed {
        logic [5:0] device_offset;
        logic       eight_bit_mode;
        logic       upcase_input;
        logic       telnet_mode;
    } t_tcd_cfg;

    typedef struct packed {
        logic       kb_ready;
        logic       pr_ready;
        logic       pr_busy;
        logic       irq_enable;
        logic [7:0] kb_holding;
        logic [7:0] pr_holding;
        logic [1:0] discard_count;
    } t_tcd_state;

endpackage

FILE: rtl/core/tcd_exec.sv
// Single-pass execution of one item: next device state and its result.
module tcd_exec (
    input  tcd_pkg::t_tcd_cfg   i_cfg,
    input  tcd_pkg::t_tcd_state i_state,
    input  tcd_pkg::t_tcd_in    i_item,
    output tcd_pkg::t_tcd_state o_state,
    output tcd_pkg::t_tcd_out   o_result
);
    import tcd_pkg::*;

    logic [11:0] base;
    logic        below_base;
    logic [11:0] rel;
    logic        own_req;
    logic        drop;
    logic [7:0]  kb_val;
    logic [12:0] ac;
    logic        skip;
    logic        unsup;
    logic        pvalid;
    logic [7:0]  pchar;
    t_tcd_state  nxt;

    assign base       = IO_BASE + {3'b000, i_cfg.device_offset, 3'b000};
    assign below_base = i_item.opcode < base;
    assign rel        = i_item.opcode - base;
    assign own_req    = i_state.irq_enable && (i_state.kb_ready || i_state.pr_ready)
                        && !i_item.irq_inhibit;

    always_comb begin
        nxt    = i_state;
        ac     = i_item.ac_in;
        skip   = 1'b0;
        unsup  = 1'b0;
        pvalid = 1'b0;
        pchar  = 8'd0;
        drop   = 1'b0;
        kb_val = i_item.kb_byte;
        case (i_item.cmd)
            CMD_IO_INSN: begin
                if (below_base) begin
                    unsup = 1'b1;
                end else begin
                    case (rel)
                        REL_KCF: nxt.kb_ready = 1'b0;
                        REL_KSF: skip = i_state.kb_ready;
                        REL_KCC: begin
                            nxt.kb_ready = 1'b0;
                            ac[11:0]     = 12'd0;
                        end
                        REL_KRS: ac[7:0] = ac[7:0] | i_state.kb_holding;
                        REL_KIE: nxt.irq_enable = ac[0];
                        REL_KRB: begin
                            ac[11:0]     = {4'd0, i_state.kb_holding};
                            nxt.kb_ready = 1'b0;
                        end
                        REL_TFL: nxt.pr_ready = 1'b1;
                        REL_TSF: skip = i_state.pr_ready;
                        REL_TCF: nxt.pr_ready = 1'b0;
                        REL_TPC, REL_TLS: begin
                            nxt.pr_holding = ac[7:0];
                            nxt.pr_busy    = 1'b1;
                            if (rel == REL_TLS) begin
                                nxt.pr_ready = 1'b0;
                            end
                            pvalid = 1'b1;
                            pchar  = {nxt.pr_holding[7] & i_cfg.eight_bit_mode,
                                      nxt.pr_holding[6:0]};
                        end
                        REL_TSK: skip = own_req || i_item.other_tty_irq;
                        default: unsup = 1'b1;
                    endcase
                end
            end
            CMD_KB_BYTE: begin
                // IAC restarts the discard; pending count holds while telnet is off
                if (i_cfg.telnet_mode) begin
                    if (i_item.kb_byte == TELNET_IAC) begin
                        nxt.discard_count = 2'd2;
                        drop              = 1'b1;
                    end else if (i_state.discard_count != 2'd0) begin
                        nxt.discard_count = i_state.discard_count - 2'd1;
                        drop              = 1'b1;
                    end
                end
                if (!drop) begin
                    if (i_cfg.upcase_input && kb_val[6:0] >= CHAR_LC_A
                        && kb_val[6:0] <= CHAR_LC_Z) begin
                        kb_val = kb_val - CASE_DIFF;
                    end
                    if (!i_cfg.eight_bit_mode) begin
                        kb_val[7] = 1'b1;
                    end
                    nxt.kb_holding = kb_val;
                    nxt.kb_ready   = 1'b1;
                end
            end
            CMD_PR_DONE: begin
                nxt.pr_busy  = 1'b0;
                nxt.pr_ready = 1'b1;
            end
            default: begin
                nxt.kb_ready   = 1'b0;
                nxt.pr_ready   = 1'b0;
                nxt.pr_busy    = 1'b0;
                nxt.irq_enable = 1'b1;
            end
        endcase
    end

    assign o_state              = nxt;
    assign o_result.ac_out      = ac;
    assign o_result.skip        = skip;
    assign o_result.unsupported = unsup;
    assign o_result.int_request = nxt.irq_enable && (nxt.kb_ready || nxt.pr_ready)
                                  && !i_item.irq_inhibit;
    assign o_result.print_valid = pvalid;
    assign o_result.print_char  = pchar;

endmodule

FILE: rtl/core/teletype_console_device_core.sv
// Teletype console device core: decode, flag state and result buffering.
// A result is registered into the output register at the edge that accepts its item,
// or into the skid entry instead while the output is stalled.
// Throughput: one item per cycle while the input is not stalled; the device state updates at the accepting edge.
// A two-entry output buffer (result register plus skid) keeps input open while one
// result waits; input stalls only while both entries are full.
// Reset (synchronous, active low): flags clear, interrupt enable set, buffers empty.
module teletype_console_device_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tcd_pkg::t_tcd_in                 i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tcd_pkg::t_tcd_out                o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tcd_pkg::*;

    localparam t_tcd_state STATE_AT_RESET = '{kb_ready:      1'b0,
                                              pr_ready:      1'b0,
                                              pr_busy:       1'b0,
                                              irq_enable:    1'b1,
                                              kb_holding:    8'd0,
                                              pr_holding:    8'd0,
                                              discard_count: 2'd0};

    t_tcd_cfg   r_cfg;
    t_tcd_state r_state;
    t_tcd_state n_state;
    t_tcd_out   n_result;
    t_tcd_out   r_out;
    t_tcd_out   r_skid;
    logic       r_out_valid;
    logic       r_skid_valid;
    logic       in_beat;
    logic       out_free;

    tcd_exec u_exec (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_beat     = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEVICE_OFFSET: r_cfg.device_offset  <= i_cfg_data[5:0];
                CFG_EIGHT_BIT:     r_cfg.eight_bit_mode <= i_cfg_data[0];
                CFG_UPCASE:        r_cfg.upcase_input   <= i_cfg_data[0];
                CFG_TELNET:        r_cfg.telnet_mode    <= i_cfg_data[0];
                default:           r_cfg                <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_AT_RESET;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // advance skid first to keep order
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (in_beat) begin
                r_out       <= n_result;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (in_beat) begin
            // hold the stalled beat, park the new one
            r_skid       <= n_result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule
